@@ hw/rtl/fphq_pkg.sv @@
package fphq_pkg;

  localparam int ANGLE_W      = 16;
  localparam int TIME_W       = 32;
  localparam int LOCK_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int MASK_W       = 5;
  localparam int ANGLE_INPUTS = 5;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THUMB_PRESS    = 3'd0,
    REG_THUMB_RELEASE  = 3'd1,
    REG_FINGER_PRESS   = 3'd2,
    REG_FINGER_RELEASE = 3'd3,
    REG_LOCKOUT        = 3'd4
  } cfg_reg_e;

  localparam logic signed [ANGLE_W-1:0] THUMB_PRESS_RST    = 16'sd120;
  localparam logic signed [ANGLE_W-1:0] THUMB_RELEASE_RST  = 16'sd110;
  localparam logic signed [ANGLE_W-1:0] FINGER_PRESS_RST   = 16'sd200;
  localparam logic signed [ANGLE_W-1:0] FINGER_RELEASE_RST = 16'sd192;
  localparam logic [LOCK_W-1:0]         LOCKOUT_RST        = 16'd50;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] thumb_press;
    logic signed [ANGLE_W-1:0] thumb_release;
    logic signed [ANGLE_W-1:0] finger_press;
    logic signed [ANGLE_W-1:0] finger_release;
    logic [LOCK_W-1:0]         lockout;
  } cfg_t;

  // Per-finger decision for the word being retired
  typedef struct packed {
    logic pressed;
    logic press;
    logic release_ev;
  } finger_res_t;

endpackage

@@ hw/rtl/fphq_cfg_regs.sv @@
module fphq_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fphq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fphq_pkg::CFG_DATA_W-1:0]      cfg_data,
  output fphq_pkg::cfg_t                       cfg
);
  import fphq_pkg::*;

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_THUMB_PRESS:    cfg_next.thumb_press    = $signed(cfg_data);
        REG_THUMB_RELEASE:  cfg_next.thumb_release  = $signed(cfg_data);
        REG_FINGER_PRESS:   cfg_next.finger_press   = $signed(cfg_data);
        REG_FINGER_RELEASE: cfg_next.finger_release = $signed(cfg_data);
        REG_LOCKOUT:        cfg_next.lockout        = cfg_data[LOCK_W-1:0];
        default:            cfg_next = cfg; // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thumb_press    <= THUMB_PRESS_RST;
      cfg.thumb_release  <= THUMB_RELEASE_RST;
      cfg.finger_press   <= FINGER_PRESS_RST;
      cfg.finger_release <= FINGER_RELEASE_RST;
      cfg.lockout        <= LOCKOUT_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

@@ hw/rtl/fphq_finger.sv @@
module fphq_finger (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic signed [fphq_pkg::ANGLE_W-1:0] angle,
  input  logic [fphq_pkg::TIME_W-1:0]         now,
  input  logic signed [fphq_pkg::ANGLE_W-1:0] press_level,
  input  logic signed [fphq_pkg::ANGLE_W-1:0] release_level,
  input  logic [fphq_pkg::LOCK_W-1:0]         lockout,
  output fphq_pkg::finger_res_t               res
);
  import fphq_pkg::*;

  logic              pressed;
  logic [TIME_W-1:0] last_change;
  logic [TIME_W-1:0] elapsed;
  logic              unlocked;
  logic              press_go;
  logic              release_go;

  // wrapping difference, so a backwards timestamp reads as long elapsed
  assign elapsed    = now - last_change;
  assign unlocked   = elapsed > {{(TIME_W-LOCK_W){1'b0}}, lockout};
  assign press_go   = !pressed && (angle > press_level) && unlocked;
  assign release_go = pressed && (angle < release_level) && unlocked;

  assign res.press      = press_go;
  assign res.release_ev = release_go;
  assign res.pressed    = pressed ^ (press_go | release_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed     <= 1'b0;
      last_change <= '0;
    end else if (take) begin
      pressed <= res.pressed;
      if (press_go || release_go) begin
        last_change <= now;
      end
    end
  end

endmodule

@@ hw/rtl/finger_press_hysteresis_qualifier.sv @@
// Finger press qualifier: five signed bend angles plus a wrapping millisecond
// time come in as one word; one word of masks goes out for each (pressed
// fingers, new presses, new releases; bit 0 thumb through bit 4 pinky). Each
// finger is a hysteresis comparator: released -> pressed when its angle is
// strictly above the press level, pressed -> released when strictly below the
// release level, and a change is taken only when strictly more than lockout_ms
// has passed (mod 2^32) since that finger's last change. Levels are used as
// written, even inverted. Throughput is one word per clock while out_stall
// does not hold the result; a word passes through the input register, then
// the result register. The per-cycle path is one 32-bit subtract and compare per
// finger in parallel, with the finger state updated as the word retires into
// the result register, so consecutive words see each other's updates.
// Configuration writes land immediately and are meant for idle periods.
// FINGER_COUNT picks how many fingers are evaluated (at most five); bits of
// the others stay zero.
module finger_press_hysteresis_qualifier #(
  parameter int FINGER_COUNT = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_write,
  input  logic [fphq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fphq_pkg::CFG_DATA_W-1:0]        cfg_data,
  // sample channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [fphq_pkg::ANGLE_W-1:0]    thumb_angle,
  input  logic signed [fphq_pkg::ANGLE_W-1:0]    index_angle,
  input  logic signed [fphq_pkg::ANGLE_W-1:0]    middle_angle,
  input  logic signed [fphq_pkg::ANGLE_W-1:0]    ring_angle,
  input  logic signed [fphq_pkg::ANGLE_W-1:0]    pinky_angle,
  input  logic [fphq_pkg::TIME_W-1:0]            now_ms,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [fphq_pkg::MASK_W-1:0]            pressed_mask,
  output logic [fphq_pkg::MASK_W-1:0]            press_events,
  output logic [fphq_pkg::MASK_W-1:0]            release_events
);
  import fphq_pkg::*;

  localparam int ACTIVE = (FINGER_COUNT < ANGLE_INPUTS) ? FINGER_COUNT : ANGLE_INPUTS;

  cfg_t cfg;

  fphq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  logic                      s1_valid;
  logic                      s1_take;
  logic                      in_take;
  logic signed [ANGLE_W-1:0] in_angle [ANGLE_INPUTS];
  logic signed [ANGLE_W-1:0] s1_angle [ANGLE_INPUTS];
  logic [TIME_W-1:0]         s1_now;

  assign in_angle[0] = thumb_angle;
  assign in_angle[1] = index_angle;
  assign in_angle[2] = middle_angle;
  assign in_angle[3] = ring_angle;
  assign in_angle[4] = pinky_angle;

  // the held word retires whenever the result register is free or draining
  assign s1_take  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_angle <= in_angle;
      s1_now   <= now_ms;
    end
  end

  // per-finger comparators; finger 0 is the thumb with its own levels
  finger_res_t res [ACTIVE];

  for (genvar i = 0; i < ACTIVE; i++) begin : g_finger
    fphq_finger u_finger (
      .clk           (clk),
      .rst           (rst),
      .take          (s1_take),
      .angle         (s1_angle[i]),
      .now           (s1_now),
      .press_level   ((i == 0) ? cfg.thumb_press   : cfg.finger_press),
      .release_level ((i == 0) ? cfg.thumb_release : cfg.finger_release),
      .lockout       (cfg.lockout),
      .res           (res[i])
    );
  end

  logic [MASK_W-1:0] pressed_mask_next;
  logic [MASK_W-1:0] press_events_next;
  logic [MASK_W-1:0] release_events_next;

  always_comb begin
    pressed_mask_next   = '0;
    press_events_next   = '0;
    release_events_next = '0;
    for (int i = 0; i < ACTIVE; i++) begin
      pressed_mask_next[i]   = res[i].pressed;
      press_events_next[i]   = res[i].press;
      release_events_next[i] = res[i].release_ev;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      pressed_mask   <= pressed_mask_next;
      press_events   <= press_events_next;
      release_events <= release_events_next;
    end
  end

endmodule

@@ hw/rtl/fphq_checker.sv @@
module fphq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [fphq_pkg::MASK_W-1:0]       pressed_mask,
  input logic [fphq_pkg::MASK_W-1:0]       press_events,
  input logic [fphq_pkg::MASK_W-1:0]       release_events
);

  // a finger cannot both press and release on one word
  a_events_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_events & release_events) == '0))
    else $error("press and release on the same finger");

  // events agree with the pressed state they report
  a_events_match_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((press_events & ~pressed_mask) == '0) &&
                   ((release_events & pressed_mask) == '0)))
    else $error("event mask disagrees with pressed mask");

  // a word taken and followed at once by the next: state carries across
  a_state_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall ##1 out_valid |->
      pressed_mask == (($past(pressed_mask) | press_events) & ~release_events))
    else $error("pressed mask does not follow from previous word");

  // a fresh result follows an accepted sample, through the input register and then the result register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without accepted sample");

  // protocol: a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressed_mask) &&
      $stable(press_events) && $stable(release_events))
    else $error("stalled result changed");

endmodule

bind finger_press_hysteresis_qualifier fphq_checker u_fphq_checker (.*);
